[rtl/core/mcwd_pkg.sv]
// ----------------------------------------------------------------------------
// Watchdog table package
// Shared types, codes and constants of the multi-channel watchdog table.
// ----------------------------------------------------------------------------
package mcwd_pkg;

   // Default table size and command queue depth.
   localparam int SLOTS_DEFAULT       = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Field widths.
   localparam int WORD_W   = 32;
   localparam int RATE_W   = 10;

   // Reset value of the tick rate register.
   localparam logic [RATE_W-1:0] TICK_RATE_RESET = 10'd100;

   // Millisecond to tick conversion: a 42-bit product divided by 1000,
   // four quotient bits per step over a 44-bit padded dividend.
   localparam int DIVISOR    = 1000;
   localparam int PROD_W     = WORD_W + RATE_W;
   localparam int DIG_W      = 4;
   localparam int DIV_STEPS  = 11;
   localparam int DIVIDEND_W = DIG_W * DIV_STEPS;
   localparam int REM_W      = 10;
   localparam int PART_W     = REM_W + DIG_W;

   // Input action codes.
   typedef enum logic [1:0] {
      ACT_CREATE = 2'd0,
      ACT_FEED   = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Classified operations handed from the front to the back.
   typedef enum logic [2:0] {
      OP_CREATE,
      OP_INVALID,
      OP_FEED,
      OP_DELETE,
      OP_TICK
   } op_type;

   // One queued command.
   typedef struct packed {
      op_type             op;
      logic [WORD_W-1:0]  limit_ticks;
      logic [WORD_W-1:0]  target_id;
   } cmd_type;

   // One table entry.
   typedef struct packed {
      logic [WORD_W-1:0]  slot_id;
      logic [WORD_W-1:0]  limit_ticks;
      logic [WORD_W-1:0]  fed_tick;
   } slot_type;

   // One result transaction.
   typedef struct packed {
      status_type         status;
      logic [WORD_W-1:0]  new_id;
      logic               timed_out;
      logic [WORD_W-1:0]  expired_id;
   } rsp_type;

   // Front state machine.
   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_DIV,
      F_PUSH
   } front_state_type;

   // Back state machine.
   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_RESULT
   } back_state_type;

endpackage

[rtl/core/mcwd_front.sv]
// ----------------------------------------------------------------------------
// Watchdog table front end
// Accepts request transactions, classifies them and converts create
// timeouts from milliseconds to ticks before queueing the command.
// ----------------------------------------------------------------------------
module mcwd_front
   import mcwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_action,
   input  logic [WORD_W-1:0]    req_period_ms,
   input  logic [WORD_W-1:0]    req_target_id,
   input  logic [RATE_W-1:0]    tick_rate_hz,
   output logic                 q_push,
   output cmd_type              q_data,
   input  logic                 q_full
);

   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

   front_state_type          state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [WORD_W-1:0]        tmo_ff, tmo_in;
   logic [DIVIDEND_W-1:0]    dividend_ff, dividend_in;
   logic [DIVIDEND_W-1:0]    quot_ff, quot_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [PROD_W-1:0]        prod;
   logic [PART_W-1:0]        part;
   logic [PART_W-1:0]        part_sub;
   logic [DIG_W-1:0]         digit;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tmo_ff      <= tmo_in;
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
   end

   // Product of the timeout and the tick rate.
   assign prod = PROD_W'(tmo_ff) * PROD_W'(tick_rate_hz);

   // One quotient digit of the division by 1000.
   always_comb begin
      part     = {rem_ff, dividend_ff[DIVIDEND_W-1 -: DIG_W]};
      digit    = '0;
      part_sub = '0;
      for (int k = 1; k < (1 << DIG_W); k++) begin
         if (part >= PART_W'(k * DIVISOR)) begin
            digit    = DIG_W'(k);
            part_sub = PART_W'(k * DIVISOR);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               if ((action_type'(req_action) == ACT_CREATE) && (req_period_ms != '0)) begin
                  state_in = F_MUL;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MUL: begin
            state_in = F_DIV;
         end
         F_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in      = cmd_ff;
      tmo_in      = tmo_ff;
      dividend_in = dividend_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      q_push      = 1'b0;
      req_full    = 1'b1;
      unique case (state_ff)
         F_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               tmo_in             = req_period_ms;
               cmd_in.target_id   = req_target_id;
               cmd_in.limit_ticks = '0;
               unique case (action_type'(req_action))
                  ACT_CREATE: begin
                     cmd_in.op = (req_period_ms == '0) ? OP_INVALID : OP_CREATE;
                  end
                  ACT_FEED: begin
                     cmd_in.op = OP_FEED;
                  end
                  ACT_DELETE: begin
                     cmd_in.op = OP_DELETE;
                  end
                  ACT_TICK: begin
                     cmd_in.op = OP_TICK;
                  end
                  default: begin
                     cmd_in.op = OP_TICK;
                  end
               endcase
            end
         end
         F_MUL: begin
            dividend_in = DIVIDEND_W'(prod);
            quot_in     = '0;
            rem_in      = '0;
            step_in     = '0;
         end
         F_DIV: begin
            dividend_in = dividend_ff << DIG_W;
            quot_in     = {quot_ff[DIVIDEND_W-DIG_W-1:0], digit};
            rem_in      = REM_W'(part - part_sub);
            step_in     = step_ff + 1'b1;
            // A quotient above the word range saturates.
            if (quot_in[DIVIDEND_W-1:WORD_W] != '0) begin
               cmd_in.limit_ticks = '1;
            end else begin
               cmd_in.limit_ticks = quot_in[WORD_W-1:0];
            end
         end
         F_PUSH: begin
            q_push = !q_full;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   assign q_data = cmd_ff;

endmodule

[rtl/core/mcwd_queue.sv]
// ----------------------------------------------------------------------------
// Watchdog command queue
// Short first-in first-out queue of classified commands between the front
// end and the table back end.
// ----------------------------------------------------------------------------
module mcwd_queue
   import mcwd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_data,
   output logic     full,
   input  logic     pop,
   output cmd_type  pop_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/mcwd_back.sv]
// ----------------------------------------------------------------------------
// Watchdog table back end
// Holds the channel table, runs each queued command but a rejected create
// as a sequential scan over the slots, then presents the result transaction.
// ----------------------------------------------------------------------------
module mcwd_back
   import mcwd_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  cmd_type              q_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]     eval_idx_ff;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [WORD_W-1:0]    now_ff, now_in;
   logic [WORD_W-1:0]    next_id_ff, next_id_in;
   logic                 tout_ff, tout_in;
   logic [WORD_W-1:0]    eid_ff, eid_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_data_ff;
   slot_type             slot_mem [SLOTS];
   slot_type             rd_data_ff;
   logic                 mem_we;
   slot_type             mem_wdata;
   logic                 scan_done;
   logic                 rsp_load;
   logic                 eval_slot_vld;
   logic [WORD_W-1:0]    elapsed;
   logic                 expired;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         cnt_ff      <= '0;
         eval_vld_ff <= 1'b0;
         valid_ff    <= '0;
         now_ff      <= '0;
         next_id_ff  <= WORD_W'(1);
         tout_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         eval_vld_ff <= eval_vld_in;
         valid_ff    <= valid_in;
         now_ff      <= now_in;
         next_id_ff  <= next_id_in;
         tout_ff     <= tout_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      eid_ff      <= eid_in;
      res_ff      <= res_in;
      eval_idx_ff <= cnt_ff[IDX_W-1:0];
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Slot table: one write port at the evaluated slot, one registered read
   // at the scan address.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[eval_idx_ff] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[cnt_ff[IDX_W-1:0]];
   end

   // Expiry test of the evaluated slot against the current time.
   assign eval_slot_vld = valid_ff[eval_idx_ff];
   assign elapsed       = now_ff - rd_data_ff.fed_tick;
   assign expired       = eval_slot_vld && (elapsed >= rd_data_ff.limit_ticks);

   // Result register hand-off to the output stage.
   assign rsp_load   = (state_ff == B_RESULT) && (!rsp_vld_ff || rsp_pop);
   assign rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_pop);
   assign rsp_empty  = !rsp_vld_ff;
   assign rsp_data   = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               state_in = (q_data.op == OP_INVALID) ? B_RESULT : B_SCAN;
            end
         end
         B_SCAN: begin
            if (scan_done) begin
               state_in = B_RESULT;
            end
         end
         B_RESULT: begin
            if (rsp_load) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Command execution.
   always_comb begin
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      eval_vld_in = 1'b0;
      valid_in    = valid_ff;
      now_in      = now_ff;
      next_id_in  = next_id_ff;
      tout_in     = tout_ff;
      eid_in      = eid_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_wdata   = rd_data_ff;
      q_pop       = 1'b0;
      scan_done   = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               cmd_in  = q_data;
               cnt_in  = '0;
               tout_in = 1'b0;
               eid_in  = '0;
               res_in  = '{status: ST_OK, new_id: '0, timed_out: 1'b0, expired_id: '0};
               if (q_data.op == OP_INVALID) begin
                  res_in.status = ST_INVALID;
               end
               // A tick advances time before its check.
               if (q_data.op == OP_TICK) begin
                  now_in = now_ff + 1'b1;
               end
            end
         end
         B_SCAN: begin
            // Issue the next slot read.
            if (cnt_ff != CNT_END) begin
               eval_vld_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
            // Evaluate the slot read in the previous cycle.
            if (eval_vld_ff) begin
               unique case (cmd_ff.op)
                  OP_CREATE: begin
                     if (!eval_slot_vld) begin
                        scan_done             = 1'b1;
                        mem_we                = 1'b1;
                        mem_wdata.slot_id     = next_id_ff;
                        mem_wdata.limit_ticks = cmd_ff.limit_ticks;
                        mem_wdata.fed_tick    = now_ff;
                        valid_in[eval_idx_ff] = 1'b1;
                        next_id_in            = next_id_ff + 1'b1;
                        res_in.new_id         = next_id_ff;
                     end else if (eval_idx_ff == IDX_LAST) begin
                        scan_done     = 1'b1;
                        res_in.status = ST_NO_SPACE;
                     end
                  end
                  OP_FEED,
                  OP_DELETE: begin
                     if (eval_slot_vld && (rd_data_ff.slot_id == cmd_ff.target_id)) begin
                        scan_done = 1'b1;
                        if (cmd_ff.op == OP_FEED) begin
                           mem_we             = 1'b1;
                           mem_wdata.fed_tick = now_ff;
                        end else begin
                           valid_in[eval_idx_ff] = 1'b0;
                        end
                     end else if (eval_idx_ff == IDX_LAST) begin
                        scan_done     = 1'b1;
                        res_in.status = ST_NOT_FOUND;
                     end
                  end
                  OP_TICK: begin
                     // Keep the largest id among expired slots.
                     if (expired && (!tout_ff || (rd_data_ff.slot_id > eid_ff))) begin
                        eid_in = rd_data_ff.slot_id;
                     end
                     if (expired) begin
                        tout_in = 1'b1;
                     end
                     if (eval_idx_ff == IDX_LAST) begin
                        scan_done         = 1'b1;
                        res_in.timed_out  = tout_in;
                        res_in.expired_id = eid_in;
                     end
                  end
                  default: begin
                     scan_done = 1'b1;
                  end
               endcase
            end
            if (scan_done) begin
               eval_vld_in = 1'b0;
            end
         end
         B_RESULT: begin
            eval_vld_in = 1'b0;
         end
         default: begin
            eval_vld_in = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/multi_channel_watchdog_table_top.sv]
// ----------------------------------------------------------------------------
// Multi-channel watchdog table
// Top level: tick rate register, front end, command queue and table back end.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter through a queue-style port: a transaction is taken on a
// clock edge with req_push high and req_full low. Results leave the same way:
// while rsp_empty is low the oldest result is on the rsp_ ports, and it is
// taken on an edge with rsp_pop high. Every request gives exactly one result,
// in request order.
// The front end takes one request at a time. Feed, delete, tick and rejected
// creates go straight to the push state; a create first passes the multiply
// state and then the divide by 1000 before it is pushed.
// The back end scans the slot table one slot per cycle through a registered
// read port until the command is settled or the last slot is read; a
// rejected create skips the scan. If the receiver stalls, one result waits
// in the output register, the back end holds one more, and the command
// queue and front end keep filling until req_full rises. Synchronous reset
// empties the table and queue, sets time to zero, the next id to one and
// the tick rate to 100. csr_wr_en writes the tick rate; the user must
// assert it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_table_top
   import mcwd_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_action,
   input  logic [WORD_W-1:0]    req_period_ms,
   input  logic [WORD_W-1:0]    req_target_id,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_status,
   output logic [WORD_W-1:0]    rsp_new_id,
   output logic                 rsp_timed_out,
   output logic [WORD_W-1:0]    rsp_expired_id,
   input  logic                 csr_wr_en,
   input  logic [RATE_W-1:0]    csr_wr_data
);

   logic [RATE_W-1:0]  tick_rate_ff;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   cmd_type            q_push_data;
   cmd_type            q_pop_data;
   rsp_type            rsp_data;

   // Tick rate register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else if (csr_wr_en) begin
         tick_rate_ff <= csr_wr_data;
      end
   end

   // Request intake and timeout conversion.
   mcwd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_period_ms  (req_period_ms),
      .req_target_id  (req_target_id),
      .tick_rate_hz   (tick_rate_ff),
      .q_push         (q_push),
      .q_data         (q_push_data),
      .q_full         (q_full)
   );

   // Command queue between front and back.
   mcwd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // Slot table and command execution.
   mcwd_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_pop_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Result fields.
   assign rsp_status     = rsp_data.status;
   assign rsp_new_id     = rsp_data.new_id;
   assign rsp_timed_out  = rsp_data.timed_out;
   assign rsp_expired_id = rsp_data.expired_id;

endmodule

[sim/multi_channel_watchdog_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog table testbench
// Drives create, feed, delete and tick transactions through the request
// queue, predicts every result with a behavioral copy of the channel table,
// and checks each popped result field by field. The tick rate register is
// rewritten between phases while the block is idle, and both sides stall at
// random.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_table_top_tb;
   import mcwd_pkg::*;

   localparam int NUM_SLOTS   = SLOTS_DEFAULT;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 235;
   localparam int CALM_ITEMS  = 150;
   localparam int SETTLE      = 8;

   // Kinds of entries in the stimulus queue.
   typedef enum logic [1:0] {
      ENT_REQ,
      ENT_RATE,
      ENT_DRAIN
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type     kind;
      action_type         action;
      logic [WORD_W-1:0]  period_ms;
      logic [WORD_W-1:0]  target_id;
      logic [RATE_W-1:0]  rate;
      logic               calm;
   } entry_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [1:0]           req_action = ACT_TICK;
   logic [WORD_W-1:0]    req_period_ms = '0;
   logic [WORD_W-1:0]    req_target_id = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [1:0]           rsp_status;
   logic [WORD_W-1:0]    rsp_new_id;
   logic                 rsp_timed_out;
   logic [WORD_W-1:0]    rsp_expired_id;
   logic                 csr_wr_en = 1'b0;
   logic [RATE_W-1:0]    csr_wr_data = '0;

   // Stimulus and expected results.
   entry_type   req_pending[$];
   rsp_type     rsp_expected[$];
   int          req_total = 0;
   int          sent_count = 0;
   int          recv_count = 0;
   int          err_count = 0;
   bit          calm_mode = 1'b0;

   // Behavioral copy of the channel table.
   logic [RATE_W-1:0]  wd_rate;
   logic               chan_valid [NUM_SLOTS];
   logic [WORD_W-1:0]  chan_id    [NUM_SLOTS];
   logic [WORD_W-1:0]  chan_limit [NUM_SLOTS];
   logic [WORD_W-1:0]  chan_fed   [NUM_SLOTS];
   logic [WORD_W-1:0]  tick_now;
   logic [WORD_W-1:0]  id_next;

   // Live ids as seen while the stimulus is built.
   logic [WORD_W-1:0]  gen_live[$];
   logic [WORD_W-1:0]  gen_next = 1;
   bit                 gen_calm = 1'b0;

   multi_channel_watchdog_table_top #(
      .SLOTS (NUM_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_period_ms  (req_period_ms),
      .req_target_id  (req_target_id),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_new_id     (rsp_new_id),
      .rsp_timed_out  (rsp_timed_out),
      .rsp_expired_id (rsp_expired_id),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Convert a millisecond timeout to ticks, saturating at the word limit.
   function automatic logic [WORD_W-1:0] ms_ticks(logic [WORD_W-1:0] ms);
      logic [63:0] quot;
      quot = ({32'd0, ms} * {54'd0, wd_rate}) / 64'd1000;
      if (quot > 64'hFFFF_FFFF)
         return '1;
      return quot[WORD_W-1:0];
   endfunction

   // Apply one transaction to the table copy and return its result.
   function automatic rsp_type watchdog_step(logic [1:0] act, logic [WORD_W-1:0] tmo,
                                              logic [WORD_W-1:0] tid);
      rsp_type            res;
      int                 slot;
      logic [WORD_W-1:0]  elapsed;
      res = '0;
      res.status = ST_OK;
      slot = -1;
      case (action_type'(act))
         ACT_CREATE: begin
            if (tmo == 0) begin
               res.status = ST_INVALID;
            end else begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (!chan_valid[i] && slot < 0)
                     slot = i;
               if (slot < 0) begin
                  res.status = ST_NO_SPACE;
               end else begin
                  chan_valid[slot] = 1'b1;
                  chan_id[slot]    = id_next;
                  chan_limit[slot] = ms_ticks(tmo);
                  chan_fed[slot]   = tick_now;
                  res.new_id       = id_next;
                  id_next          = id_next + 1;
               end
            end
         end
         ACT_FEED, ACT_DELETE: begin
            // Only the lowest matching slot is touched.
            for (int i = 0; i < NUM_SLOTS; i++)
               if (chan_valid[i] && chan_id[i] == tid && slot < 0)
                  slot = i;
            if (slot < 0)
               res.status = ST_NOT_FOUND;
            else if (action_type'(act) == ACT_FEED)
               chan_fed[slot] = tick_now;
            else
               chan_valid[slot] = 1'b0;
         end
         default: begin
            tick_now = tick_now + 1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               elapsed = tick_now - chan_fed[i];
               if (chan_valid[i] && elapsed >= chan_limit[i]) begin
                  if (!res.timed_out || chan_id[i] > res.expired_id)
                     res.expired_id = chan_id[i];
                  res.timed_out = 1'b1;
               end
            end
         end
      endcase
      return res;
   endfunction

   // Queue one request and track which ids will be live.
   function automatic void add_req(action_type act, logic [WORD_W-1:0] tmo,
                                   logic [WORD_W-1:0] tid);
      entry_type ent;
      ent = '0;
      ent.kind      = ENT_REQ;
      ent.action    = act;
      ent.period_ms = tmo;
      ent.target_id = tid;
      ent.calm      = gen_calm;
      req_pending.push_back(ent);
      req_total++;
      if (act == ACT_CREATE && tmo != 0 && gen_live.size() < NUM_SLOTS) begin
         gen_live.push_back(gen_next);
         gen_next++;
      end else if (act == ACT_DELETE) begin
         for (int i = 0; i < gen_live.size(); i++)
            if (gen_live[i] == tid) begin
               gen_live.delete(i);
               break;
            end
      end
   endfunction

   // Queue a pause until idle, optionally followed by a tick rate write.
   function automatic void add_marker(entry_kind_type kind, logic [RATE_W-1:0] rate);
      entry_type ent;
      ent = '0;
      ent.kind = kind;
      ent.rate = rate;
      ent.calm = gen_calm;
      req_pending.push_back(ent);
   endfunction

   // Mostly live ids, sometimes ids that are not in the table.
   function automatic logic [WORD_W-1:0] pick_target();
      int r;
      r = $urandom_range(0, 99);
      if (gen_live.size() != 0 && r < 80)
         return gen_live[$urandom_range(0, gen_live.size() - 1)];
      if (r < 88)
         return $urandom;
      if (r < 92)
         return '0;
      if (r < 96)
         return '1;
      return gen_next + $urandom_range(0, 3);
   endfunction

   // Mostly short timeouts so channels expire within a phase.
   function automatic logic [WORD_W-1:0] pick_timeout();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)
         return '0;
      if (r < 16)
         return $urandom;
      if (r < 20)
         return '1;
      return $urandom_range(1, 400);
   endfunction

   // Feed the request port from the stimulus queue and apply rate writes once
   // nothing is outstanding.
   always @(posedge clock) begin : drv_proc
      entry_type  ent;
      logic       nxt_push;
      logic       nxt_wr;
      int         gap_cnt;
      int         quiet_cnt;
      bit         idle_on;
      if (reset) begin
         req_push  <= 1'b0;
         csr_wr_en <= 1'b0;
         gap_cnt   = 0;
         quiet_cnt = 0;
         idle_on   = 1'b1;
      end else begin
         nxt_push = req_push;
         nxt_wr   = 1'b0;
         if (req_push && !req_full) begin
            rsp_expected.push_back(watchdog_step(req_action, req_period_ms,
                                                 req_target_id));
            nxt_push = 1'b0;
            sent_count++;
            if (sent_count % 64 == 0)
               idle_on = ($urandom_range(0, 2) != 0);
            if (!calm_mode && idle_on && $urandom_range(0, 3) == 0)
               gap_cnt = $urandom_range(1, 13);
         end
         if (!nxt_push && req_pending.size() != 0) begin
            if (gap_cnt != 0) begin
               gap_cnt--;
            end else begin
               ent = req_pending[0];
               calm_mode = ent.calm;
               if (ent.kind == ENT_REQ) begin
                  ent = req_pending.pop_front();
                  nxt_push = 1'b1;
                  req_action     <= ent.action;
                  req_period_ms  <= ent.period_ms;
                  req_target_id  <= ent.target_id;
               end else if (rsp_expected.size() != 0) begin
                  quiet_cnt = 0;
               end else if (quiet_cnt < SETTLE) begin
                  quiet_cnt++;
               end else begin
                  ent = req_pending.pop_front();
                  quiet_cnt = 0;
                  if (ent.kind == ENT_RATE) begin
                     nxt_wr = 1'b1;
                     csr_wr_data <= ent.rate;
                     wd_rate = ent.rate;
                  end
               end
            end
         end
         req_push  <= nxt_push;
         csr_wr_en <= nxt_wr;
      end
   end

   // Report a failure; only the first ten are printed.
   task automatic note_error(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      err_count++;
      if (err_count <= 10)
         $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h",
                  $realtime, what, want, got);
   endtask

   // Pop results with random stalls and compare them with the oldest
   // expectation.
   always @(posedge clock) begin : mon_proc
      rsp_type  want;
      int       hold_cnt;
      bit       idle_on;
      if (reset) begin
         rsp_pop  <= 1'b0;
         hold_cnt = 0;
         idle_on  = 1'b1;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            recv_count++;
            if (rsp_expected.size() == 0) begin
               note_error("unexpected result", '0, {30'd0, rsp_status});
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_status != want.status)
                  note_error("status", 32'(want.status), 32'(rsp_status));
               if (rsp_new_id != want.new_id)
                  note_error("new_id", want.new_id, rsp_new_id);
               if (rsp_timed_out != want.timed_out)
                  note_error("timed_out", 32'(want.timed_out), 32'(rsp_timed_out));
               if (rsp_expired_id != want.expired_id)
                  note_error("expired_id", want.expired_id, rsp_expired_id);
            end
            if (recv_count % 64 == 0)
               idle_on = ($urandom_range(0, 2) != 0);
            if (!calm_mode && idle_on && $urandom_range(0, 3) == 0)
               hold_cnt = $urandom_range(1, 13);
         end
         if (hold_cnt != 0) begin
            hold_cnt--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Build the stimulus, release reset and wait for the run to drain.
   initial begin : main_proc
      logic [RATE_W-1:0]  rate_plan [NUM_PHASES];
      int                 r;
      int                 item_idx;
      wd_rate  = TICK_RATE_RESET;
      tick_now = '0;
      id_next  = 1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         chan_valid[i] = 1'b0;
         chan_id[i]    = '0;
         chan_limit[i] = '0;
         chan_fed[i]   = '0;
      end

      // Directed part at the reset tick rate.
      add_req(ACT_TICK, '0, '0);
      add_req(ACT_CREATE, '0, '1);
      add_req(ACT_FEED, '1, '1);
      add_req(ACT_DELETE, '1, '0);
      add_req(ACT_CREATE, '1, '0);
      add_req(ACT_CREATE, 32'd5, '0);
      add_req(ACT_CREATE, 32'd10, '0);
      add_req(ACT_TICK, '1, '1);
      add_req(ACT_FEED, '0, 32'd3);
      add_req(ACT_TICK, '0, '0);
      add_req(ACT_DELETE, '0, 32'd2);
      add_req(ACT_DELETE, '0, 32'd2);
      while (gen_live.size() < NUM_SLOTS)
         add_req(ACT_CREATE, 32'd20 + gen_live.size(), '0);
      add_req(ACT_CREATE, 32'd30, '0);
      add_req(ACT_TICK, '0, '0);

      // Random phases, each at its own tick rate, extremes included.
      rate_plan = '{10'd0, 10'd1, 10'd1000, 10'd1023, 10'd100, 10'd7, 10'd0, 10'd250};
      rate_plan[6] = RATE_W'($urandom_range(1, 1000));
      item_idx = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         add_marker(ENT_RATE, rate_plan[p]);
         // Make room, then try the largest timeout at this rate.
         if (gen_live.size() == NUM_SLOTS)
            add_req(ACT_DELETE, '0, gen_live[0]);
         add_req(ACT_CREATE, '1, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gen_calm = (item_idx >= NUM_PHASES * PHASE_ITEMS - CALM_ITEMS);
            item_idx++;
            if (p == 3 && n == PHASE_ITEMS / 2)
               add_marker(ENT_DRAIN, '0);
            r = $urandom_range(0, 99);
            if (r < 28)
               add_req(ACT_CREATE, pick_timeout(), $urandom);
            else if (r < 48)
               add_req(ACT_FEED, $urandom, pick_target());
            else if (r < 70)
               add_req(ACT_DELETE, $urandom, pick_target());
            else
               add_req(ACT_TICK, $urandom, $urandom);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (sent_count < req_total || recv_count < req_total || rsp_expected.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (rsp_expected.size() != 0)
         note_error("missing results", '0, rsp_expected.size());
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Stop a hung run.
   initial begin : limit_proc
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
